[hdl/lcwsd_pkg.sv]
// shared types and constants for the lcw stream decompressor
package lcwsd_pkg;

  localparam int POS_W = 17;
  localparam int CNT_W = 16;
  localparam int DEFAULT_HISTORY_DEPTH = 65536;
  localparam logic [POS_W-1:0] RESET_OUTPUT_LENGTH = 17'h10000;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  localparam logic [7:0] OP_FILL = 8'hFE;
  localparam logic [7:0] OP_LONG = 8'hFF;
  localparam logic [7:0] FIRST_RELATIVE = 8'h00;
  localparam logic [CNT_W-1:0] COPY_BIAS = 16'd3;

  typedef enum logic [2:0] {
    ST_DECODING   = 3'd0,
    ST_END_MARKER = 3'd1,
    ST_LENGTH     = 3'd2,
    ST_BAD_REF    = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_t;

  typedef struct packed {
    logic             emit;
    logic             is_copy;
    logic [7:0]       data;
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] wr_pos;
    logic             need;
    status_t          status;
    logic [POS_W-1:0] count;
  } step_t;

endpackage

[hdl/lcw_stream_decompressor_unit.sv]
// lcw stream decompressor top level: stream handshake, history read stage, output register
// an accepted transaction is held in the s1 register, then in the output register
// throughput: one transaction per cycle unless stalled, set by the single read port of the
//   history memory; a copy one byte behind wr_pos uses a one-entry write-to-read bypass
// reset: synchronous, clears decoder state and pipeline valids; output length returns to 65536
//   capped at HISTORY_DEPTH; history contents are not cleared
module lcw_stream_decompressor_unit #(
  parameter int HISTORY_DEPTH = lcwsd_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // in_byte[7:0], start_req[8]
  input  logic                        s_axis_tuser,  // kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // out_byte[7:0], need_byte[8],
                                                     // status[11:9], written_count[28:12]
  output logic                        m_axis_tuser,  // out_valid
  input  logic                        cfg_we,
  input  logic [lcwsd_pkg::POS_W-1:0] cfg_wdata
);
  import lcwsd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  step_t      step;
  step_t      s1;
  logic       s1_valid;
  logic       s1_move;
  logic       accept;
  logic [7:0] s1_byte;
  logic       fwd_hit;
  logic [7:0] fwd_data;
  logic [7:0] rdata;
  logic       mem_we;
  logic       mem_re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lcwsd_decode_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step_en   (accept),
    .kind      (s_axis_tuser),
    .in_byte   (s_axis_tdata[7:0]),
    .start_req (s_axis_tdata[8]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step)
  );

  assign s1_byte = s1.is_copy ? (fwd_hit ? fwd_data : rdata) : s1.data;
  assign mem_we  = s1_move && s1.emit;
  assign waddr   = s1.wr_pos[AW-1:0];
  assign mem_re  = accept && step.is_copy;
  assign raddr   = step.rd_pos[AW-1:0];

  lcwsd_history_ram #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (s1_byte),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read issued in the same cycle as the write to that entry sees old data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1       <= step;
      fwd_hit  <= mem_we && (waddr == raddr);
      fwd_data <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_move) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (s1_move) begin
      m_axis_tdata <= {3'b000, s1.count, s1.status, s1.need, s1_byte};
      m_axis_tuser <= s1.emit;
    end
  end

endmodule

[hdl/lcwsd_history_ram.sv]
// history memory, one write port and one registered read port
module lcwsd_history_ram #(
  parameter int DEPTH = lcwsd_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lcwsd_decode_ctrl.sv]
// command decoder state and next-state logic, one transaction per step
module lcwsd_decode_ctrl #(
  parameter int HISTORY_DEPTH = lcwsd_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  logic                      kind,
  input  logic [7:0]                in_byte,
  input  logic                      start_req,
  input  logic                      cfg_we,
  input  logic [lcwsd_pkg::POS_W-1:0] cfg_wdata,
  output lcwsd_pkg::step_t          step
);
  import lcwsd_pkg::*;

  typedef enum logic [3:0] {
    PH_FIRST    = 4'd0,
    PH_OP       = 4'd1,
    PH_SHORT_LO = 4'd2,
    PH_LIT      = 4'd3,
    PH_FILL_C0  = 4'd4,
    PH_FILL_C1  = 4'd5,
    PH_FILL_V   = 4'd6,
    PH_LONG_C0  = 4'd7,
    PH_LONG_C1  = 4'd8,
    PH_LONG_P0  = 4'd9,
    PH_LONG_P1  = 4'd10,
    PH_MED_P0   = 4'd11,
    PH_MED_P1   = 4'd12,
    PH_COPY     = 4'd13,
    PH_FILL     = 4'd14,
    PH_STOP     = 4'd15
  } phase_t;

  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(HISTORY_DEPTH);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] wp, wp_next;
  logic [CNT_W-1:0] rem, rem_next;
  logic [POS_W-1:0] src, src_next;
  logic [7:0]       fill, fill_next;
  logic [7:0]       lo, lo_next;
  logic             rel, rel_next;
  status_t          stop, stop_next;
  logic [POS_W-1:0] len;

  always_comb begin
    phase_t           ph;
    logic [POS_W-1:0] wp_c;
    logic [CNT_W-1:0] rem_c;
    logic [POS_W-1:0] src_c;
    logic [7:0]       fill_c;
    logic [7:0]       lo_c;
    logic             rel_c;
    status_t          stop_c;
    logic [POS_W-1:0] room;
    logic             at_end;
    logic             pulls;
    logic             unexp;
    logic             do_emit;
    logic             do_op;
    logic             do_copy;
    logic [7:0]       emit_data;
    logic [CNT_W-1:0] cp_pos;
    logic             cp_rel;
    logic [CNT_W-1:0] cp_cnt;
    logic [POS_W-1:0] cp_src;
    logic [POS_W-1:0] cl;
    logic [CNT_W-1:0] rem_dec;
    logic [5:0]       lit_n;

    ph     = start_req ? PH_FIRST : phase;
    wp_c   = start_req ? '0 : wp;
    rem_c  = start_req ? '0 : rem;
    src_c  = start_req ? '0 : src;
    fill_c = start_req ? '0 : fill;
    lo_c   = start_req ? '0 : lo;
    rel_c  = start_req ? 1'b0 : rel;
    stop_c = start_req ? ST_DECODING : stop;

    room   = (wp_c < len) ? len - wp_c : '0;
    at_end = wp_c >= len;

    phase_next = ph;
    wp_next    = wp_c;
    rem_next   = rem_c;
    src_next   = src_c;
    fill_next  = fill_c;
    lo_next    = lo_c;
    rel_next   = rel_c;
    stop_next  = stop_c;

    unexp     = 1'b0;
    do_emit   = 1'b0;
    do_op     = 1'b0;
    do_copy   = 1'b0;
    emit_data = 8'h00;
    cp_pos    = '0;
    cp_rel    = 1'b0;
    cp_cnt    = rem_c;
    cp_src    = '0;
    cl        = '0;
    rem_dec   = '0;
    lit_n     = in_byte[5:0];
    pulls     = (ph == PH_COPY) || (ph == PH_FILL);

    step.is_copy = 1'b0;

    if (ph != PH_STOP) begin
      if ((kind == KIND_PULL) != pulls) begin
        unexp = 1'b1;
      end else if (pulls) begin
        do_emit = 1'b1;
        if (ph == PH_COPY) begin
          step.is_copy = 1'b1;
          src_next     = src_c + 1'b1;
        end else begin
          emit_data = fill_c;
        end
      end else begin
        unique case (ph) inside
          PH_FIRST: begin
            if (len == '0) begin
              phase_next = PH_STOP;
              stop_next  = ST_LENGTH;
            end else if (in_byte == FIRST_RELATIVE) begin
              rel_next   = 1'b1;
              phase_next = PH_OP;
            end else begin
              rel_next = 1'b0;
              do_op    = 1'b1;
            end
          end
          PH_OP: do_op = 1'b1;
          PH_SHORT_LO: begin
            do_copy = 1'b1;
            cp_pos  = CNT_W'({src_c[3:0], in_byte});
            cp_rel  = 1'b1;
          end
          PH_LIT: begin
            do_emit   = 1'b1;
            emit_data = in_byte;
          end
          PH_FILL_C0: begin
            lo_next    = in_byte;
            phase_next = PH_FILL_C1;
          end
          PH_LONG_C0: begin
            lo_next    = in_byte;
            phase_next = PH_LONG_C1;
          end
          PH_LONG_P0: begin
            lo_next    = in_byte;
            phase_next = PH_LONG_P1;
          end
          PH_MED_P0: begin
            lo_next    = in_byte;
            phase_next = PH_MED_P1;
          end
          PH_FILL_C1: begin
            rem_next   = {in_byte, lo_c};
            phase_next = PH_FILL_V;
          end
          PH_LONG_C1: begin
            rem_next   = {in_byte, lo_c};
            phase_next = PH_LONG_P0;
          end
          PH_FILL_V: begin
            fill_next = in_byte;
            cl        = ({1'b0, rem_c} > room) ? room : {1'b0, rem_c};
            rem_next  = cl[CNT_W-1:0];
            if (cl == '0) begin
              if (at_end) begin
                phase_next = PH_STOP;
                stop_next  = ST_LENGTH;
              end else begin
                phase_next = PH_OP;
              end
            end else begin
              phase_next = PH_FILL;
            end
          end
          PH_LONG_P1, PH_MED_P1: begin
            do_copy = 1'b1;
            cp_pos  = {in_byte, lo_c};
            cp_rel  = rel_c;
          end
          default: begin
            phase_next = ph;
          end
        endcase
      end
    end

    if (do_op) begin
      if (at_end) begin
        phase_next = PH_STOP;
        stop_next  = ST_LENGTH;
      end else if (!in_byte[7]) begin
        rem_next   = CNT_W'(in_byte[6:4]) + COPY_BIAS;
        src_next   = POS_W'(in_byte[3:0]);
        phase_next = PH_SHORT_LO;
      end else if (!in_byte[6]) begin
        if (lit_n == '0) begin
          phase_next = PH_STOP;
          stop_next  = ST_END_MARKER;
        end else begin
          cl         = (POS_W'(lit_n) > room) ? room : POS_W'(lit_n);
          rem_next   = cl[CNT_W-1:0];
          phase_next = PH_LIT;
        end
      end else if (in_byte == OP_FILL) begin
        phase_next = PH_FILL_C0;
      end else if (in_byte == OP_LONG) begin
        phase_next = PH_LONG_C0;
      end else begin
        rem_next   = CNT_W'(lit_n) + COPY_BIAS;
        phase_next = PH_MED_P0;
      end
    end

    if (do_copy) begin
      cp_src = cp_rel ? wp_c - POS_W'(cp_pos) : POS_W'(cp_pos);
      cl     = ({1'b0, cp_cnt} > room) ? room : {1'b0, cp_cnt};
      if (cp_rel && (POS_W'(cp_pos) > wp_c)) begin
        phase_next = PH_STOP;
        stop_next  = ST_BAD_REF;
      end else if (cl == '0) begin
        if (at_end) begin
          phase_next = PH_STOP;
          stop_next  = ST_LENGTH;
        end else begin
          phase_next = PH_OP;
        end
      end else if (cp_src >= wp_c) begin
        phase_next = PH_STOP;
        stop_next  = ST_BAD_REF;
      end else begin
        rem_next   = cl[CNT_W-1:0];
        src_next   = cp_src;
        phase_next = PH_COPY;
      end
    end

    if (do_emit) begin
      wp_next  = wp_c + 1'b1;
      rem_dec  = (rem_c != '0) ? rem_c - 1'b1 : rem_c;
      rem_next = rem_dec;
      if (wp_c + 1'b1 >= len) begin
        phase_next = PH_STOP;
        stop_next  = ST_LENGTH;
      end else if (rem_dec == '0) begin
        phase_next = PH_OP;
      end
    end

    step.emit   = do_emit;
    step.data   = emit_data;
    step.rd_pos = src_c;
    step.wr_pos = wp_c;
    step.need   = (phase_next != PH_STOP) && (phase_next != PH_COPY) &&
                  (phase_next != PH_FILL);
    if (unexp) begin
      step.status = ST_UNEXPECTED;
    end else if (phase_next == PH_STOP) begin
      step.status = stop_next;
    end else begin
      step.status = ST_DECODING;
    end
    step.count = wp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      wp    <= '0;
      rem   <= '0;
      src   <= '0;
      fill  <= '0;
      lo    <= '0;
      rel   <= 1'b0;
      stop  <= ST_DECODING;
      len   <= (RESET_OUTPUT_LENGTH > DEPTH_POS) ? DEPTH_POS : RESET_OUTPUT_LENGTH;
    end else begin
      if (step_en) begin
        phase <= phase_next;
        wp    <= wp_next;
        rem   <= rem_next;
        src   <= src_next;
        fill  <= fill_next;
        lo    <= lo_next;
        rel   <= rel_next;
        stop  <= stop_next;
      end
      if (cfg_we) begin
        len <= (cfg_wdata > DEPTH_POS) ? DEPTH_POS : cfg_wdata;
      end
    end
  end

endmodule
